FILE: hdl/eipc_pkg.sv
`timescale 1ns / 1ps
package eipc_pkg;

	// Size of the chromosome seen map. Must be a power of two.
	localparam int MAX_CHROMS = 1024;
	localparam int SLOT_W     = $clog2(MAX_CHROMS);

	localparam int CHROM_W = 10;
	localparam int POS_W   = 31;
	localparam int NAME_W  = 32;
	localparam int CNT_W   = 32;
	localparam int SUM_W   = 48;
	localparam int STAT_W  = 2;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_REVISIT   = 2'd1;
	localparam logic [STAT_W-1:0] ST_START_DEC = 2'd2;

	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_END    = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [CHROM_W-1:0] chrom;
		logic [POS_W-1:0]   start;
		logic [POS_W-1:0]   stop;
		logic [NAME_W-1:0]  name;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [CNT_W-1:0]   pileups;
		logic [SUM_W-1:0]   size_sum;
		logic [CNT_W-1:0]   best_size;
		logic [CHROM_W-1:0] best_chrom;
		logic [POS_W-1:0]   best_start;
		logic [POS_W-1:0]   best_end;
	} stats_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
	} map_wr_t;

	// Seen map slot of a chromosome id (id modulo the map size).
	function automatic logic [SLOT_W-1:0] slot_of(logic [CHROM_W-1:0] c);
		logic [31:0] wide;
		wide = 32'(c) % MAX_CHROMS;
		return wide[SLOT_W-1:0];
	endfunction

endpackage

FILE: hdl/eipc_ifs.sv
`timescale 1ns / 1ps
interface eipc_item_if;
	import eipc_pkg::*;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [CHROM_W-1:0] chrom_id;
	logic [POS_W-1:0]   start_pos;
	logic [POS_W-1:0]   end_pos;
	logic [NAME_W-1:0]  name_id;
	modport source (output valid, mode, chrom_id, start_pos, end_pos, name_id, input ready);
	modport sink (input valid, mode, chrom_id, start_pos, end_pos, name_id, output ready);
endinterface

interface eipc_result_if;
	import eipc_pkg::*;
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [CNT_W-1:0]   pileups_found;
	logic [SUM_W-1:0]   size_sum;
	logic [CNT_W-1:0]   largest_size;
	logic [CHROM_W-1:0] largest_chrom;
	logic [POS_W-1:0]   largest_start;
	logic [POS_W-1:0]   largest_end;
	logic               finished;
	modport source (output valid, status, pileups_found, size_sum, largest_size,
		largest_chrom, largest_start, largest_end, finished, input ready);
	modport sink (input valid, status, pileups_found, size_sum, largest_size,
		largest_chrom, largest_start, largest_end, finished, output ready);
endinterface

interface eipc_cfg_if;
	logic valid;
	logic ready;
	logic compare_name;
	modport source (output valid, compare_name, input ready);
	modport sink (input valid, compare_name, output ready);
endinterface

FILE: hdl/exact_interval_pileup_counter.sv
`timescale 1ns / 1ps
// A request is captured in the input register and its result is then
// offered from the result register.
// Throughput: one request per cycle while results are taken and the seen map is not being cleared.
// Reset: after arst_n rises the chromosome seen map is cleared one entry per
// cycle; requests wait, configuration writes do not.
module exact_interval_pileup_counter (
	input logic         clk,
	input logic         arst_n,
	eipc_item_if.sink   item,
	eipc_result_if.source result,
	eipc_cfg_if.sink    cfg
);
	import eipc_pkg::*;

	// Input stage. The seen map is read at the same edge that captures the
	// request, so its bit lines up with the captured request.
	logic    valid_s1;
	item_t   item_s1;
	logic    fwd_s1;
	logic    seen_bit;
	logic    map_busy;
	logic    accept;
	logic    adv;
	map_wr_t map_wr;
	logic [SLOT_W-1:0] new_slot;

	// Result register.
	logic   res_valid_q;
	stats_t res_q;
	logic   res_fin_q;
	stats_t stats_n;

	logic compare_name_q;

	// The input stage moves on when the result register is free or being
	// drained; a waiting result that is not taken blocks a new request.
	assign adv    = valid_s1 && (!res_valid_q || result.ready);
	assign accept = item.valid && item.ready;
	assign item.ready = !map_busy && (!valid_s1 || adv);
	assign new_slot = slot_of(item.chrom_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// The request leaving the stage may mark the same slot that the new
	// request reads; the map read returns the old bit, so the mark is
	// forwarded alongside it.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.mode  <= item.mode;
			item_s1.chrom <= item.chrom_id;
			item_s1.start <= item.start_pos;
			item_s1.stop  <= item.end_pos;
			item_s1.name  <= item.name_id;
			fwd_s1        <= map_wr.en && (map_wr.slot == new_slot);
		end
	end

	eipc_seen_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_slot (new_slot),
		.rd_bit  (seen_bit),
		.wr      (map_wr),
		.busy    (map_busy)
	);

	eipc_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_s1      (item_s1),
		.seen_s1      (seen_bit || fwd_s1),
		.adv          (adv),
		.compare_name (compare_name_q),
		.stats_n      (stats_n),
		.wr           (map_wr)
	);

	// Configuration is a single bit, always writable.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_name_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			compare_name_q <= cfg.compare_name;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_q       <= '0;
			res_fin_q   <= 1'b0;
		end else begin
			if (adv) begin
				res_valid_q <= 1'b1;
				res_q       <= stats_n;
				res_fin_q   <= item_s1.mode;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid         = res_valid_q;
	assign result.status        = res_q.status;
	assign result.pileups_found = res_q.pileups;
	assign result.size_sum      = res_q.size_sum;
	assign result.largest_size  = res_q.best_size;
	assign result.largest_chrom = res_q.best_chrom;
	assign result.largest_start = res_q.best_start;
	assign result.largest_end   = res_q.best_end;
	assign result.finished      = res_fin_q;

	// The map is never marked while the clearing sweep owns its write port.
	a_no_mark_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		map_busy |-> !map_wr.en)
		else $error("seen map marked during clearing sweep");

	// An error status, once reported, is reported by every later result.
	a_status_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (res_q.status != ST_OK)) |=> (res_q.status == $past(res_q.status)))
		else $error("error status not sticky");

	// The pile-up count never goes down from one result to the next.
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (res_q.pileups >= $past(res_q.pileups)))
		else $error("pile-up count decreased");

endmodule

FILE: hdl/eipc_seen_map.sv
`timescale 1ns / 1ps
module eipc_seen_map (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [eipc_pkg::SLOT_W-1:0] rd_slot,
	output logic                       rd_bit,
	input  eipc_pkg::map_wr_t          wr,
	output logic                       busy
);
	import eipc_pkg::*;

	logic              mem [MAX_CHROMS];
	logic [SLOT_W-1:0] clr_cnt_q;
	logic              clearing_q;
	logic              seen_rd_s1;

	// After reset the map is swept to zero, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == SLOT_W'(MAX_CHROMS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_cnt_q] <= 1'b0;
		end else if (wr.en) begin
			mem[wr.slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			seen_rd_s1 <= mem[rd_slot];
		end
	end

	assign rd_bit = seen_rd_s1;
	assign busy   = clearing_q;

endmodule

FILE: hdl/eipc_tracker.sv
`timescale 1ns / 1ps
module eipc_tracker (
	input  logic              clk,
	input  logic              arst_n,
	input  eipc_pkg::item_t   item_s1,
	input  logic              seen_s1,
	input  logic              adv,
	input  logic              compare_name,
	output eipc_pkg::stats_t  stats_n,
	output eipc_pkg::map_wr_t wr
);
	import eipc_pkg::*;

	logic [CHROM_W-1:0] cur_chrom_q, cur_chrom_n;
	logic               have_chrom_q, have_chrom_n;
	logic               run_valid_q, run_valid_n;
	logic [POS_W-1:0]   run_start_q, run_start_n;
	logic [POS_W-1:0]   run_end_q, run_end_n;
	logic [NAME_W-1:0]  run_name_q, run_name_n;
	logic [CNT_W-1:0]   run_len_q, run_len_n;
	stats_t             st_q;

	logic         same_chrom;
	logic         match;
	logic         do_close;
	logic         wr_en;
	logic [SUM_W:0] sum_wide;

	always_comb begin
		cur_chrom_n  = cur_chrom_q;
		have_chrom_n = have_chrom_q;
		run_valid_n  = run_valid_q;
		run_start_n  = run_start_q;
		run_end_n    = run_end_q;
		run_name_n   = run_name_q;
		run_len_n    = run_len_q;
		stats_n      = st_q;
		wr_en        = 1'b0;
		sum_wide     = {1'b0, st_q.size_sum} + (SUM_W + 1)'(run_len_q);

		same_chrom = have_chrom_q && (item_s1.chrom == cur_chrom_q);
		match = run_valid_q && (item_s1.start == run_start_q) &&
			(item_s1.stop == run_end_q) &&
			(!compare_name || (item_s1.name == run_name_q));

		do_close = (item_s1.mode == MODE_END) || !same_chrom || !match;

		if (st_q.status == ST_OK) begin
			// Closing a run of more than one record updates the statistics.
			if (do_close && run_valid_q && (run_len_q > CNT_W'(1))) begin
				if (st_q.pileups != '1) begin
					stats_n.pileups = st_q.pileups + 1'b1;
				end
				stats_n.size_sum = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
				if (run_len_q > st_q.best_size) begin
					stats_n.best_size  = run_len_q;
					stats_n.best_chrom = cur_chrom_q;
					stats_n.best_start = run_start_q;
					stats_n.best_end   = run_end_q;
				end
			end

			if (item_s1.mode == MODE_END) begin
				run_valid_n = 1'b0;
				run_len_n   = '0;
			end else begin
				if (!same_chrom) begin
					if (seen_s1) begin
						stats_n.status = ST_REVISIT;
					end else begin
						wr_en        = 1'b1;
						cur_chrom_n  = item_s1.chrom;
						have_chrom_n = 1'b1;
						run_valid_n  = 1'b0;
						run_len_n    = '0;
						match        = 1'b0;
					end
				end
				if ((stats_n.status == ST_OK) && run_valid_n &&
						(item_s1.start < run_start_q)) begin
					stats_n.status = ST_START_DEC;
				end
				if (stats_n.status == ST_OK) begin
					if (match) begin
						if (run_len_q != '1) begin
							run_len_n = run_len_q + 1'b1;
						end
					end else begin
						run_valid_n = 1'b1;
						run_start_n = item_s1.start;
						run_end_n   = item_s1.stop;
						run_name_n  = item_s1.name;
						run_len_n   = CNT_W'(1);
					end
				end
			end
		end
	end

	assign wr.en   = adv && wr_en;
	assign wr.slot = slot_of(item_s1.chrom);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_chrom_q  <= '0;
			have_chrom_q <= 1'b0;
			run_valid_q  <= 1'b0;
			run_start_q  <= '0;
			run_end_q    <= '0;
			run_name_q   <= '0;
			run_len_q    <= '0;
			st_q         <= '0;
		end else if (adv) begin
			cur_chrom_q  <= cur_chrom_n;
			have_chrom_q <= have_chrom_n;
			run_valid_q  <= run_valid_n;
			run_start_q  <= run_start_n;
			run_end_q    <= run_end_n;
			run_name_q   <= run_name_n;
			run_len_q    <= run_len_n;
			st_q         <= stats_n;
		end
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
	import eipc_pkg::*;

	// The run is stopped by force after this many clock cycles. The slowest
	// correct run, including the seen map clearing pass after reset, stays
	// well under this limit.
	localparam int CYCLE_LIMIT = 300000;

	localparam longint POS_MAX = 64'h7FFF_FFFF;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// One expected result: the statistics snapshot plus the finished flag.
	typedef struct {
		stats_t stats;
		logic   finished;
	} pile_summary_t;

	logic clk = 1'b0;
	logic arst_n;

	eipc_item_if   item_bus ();
	eipc_result_if result_bus ();
	eipc_cfg_if    cfg_bus ();

	exact_interval_pileup_counter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting to be offered, and the summaries that the accepted
	// requests must produce, oldest first.
	item_t         pending_items[$];
	pile_summary_t expected_summaries[$];

	int cycle_count = 0;
	int fail_count  = 0;
	int queued      = 0;

	// Chromosomes already used by the stimulus. A sorted stream never
	// comes back to one of them, except for the deliberate revisit at the end.
	bit chrom_taken [MAX_CHROMS];

	// Shadow of the block's state, updated at every accepted request.
	bit                 cmp_name   = 1'b0;
	bit                 seen_map [MAX_CHROMS];
	bit [CHROM_W-1:0]   cur_chrom  = '0;
	bit                 chrom_open = 1'b0;
	bit                 run_open   = 1'b0;
	bit [POS_W-1:0]     run_lo     = '0;
	bit [POS_W-1:0]     run_hi     = '0;
	bit [NAME_W-1:0]    run_nm     = '0;
	bit [CNT_W-1:0]     run_len    = '0;
	bit [CNT_W-1:0]     n_pileups  = '0;
	bit [SUM_W-1:0]     size_total = '0;
	bit [CNT_W-1:0]     top_size   = '0;
	bit [CHROM_W-1:0]   top_chrom  = '0;
	bit [POS_W-1:0]     top_lo     = '0;
	bit [POS_W-1:0]     top_hi     = '0;
	bit [STAT_W-1:0]    err_state  = ST_OK;

	// Sender burst and gap bookkeeping.
	int burst_left = 1;
	int gap_left   = 0;

	// Receiver stall pattern.
	int stall_tick  = 0;
	int stall_style = 0;

	task automatic flag_failure(input string msg);
		fail_count++;
		if (fail_count <= 40) begin
			$display("ERROR cycle %0d: %s", cycle_count, msg);
		end
	endtask

	task automatic check_field(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			flag_failure($sformatf("%s is %0h, expected %0h", field, got, want));
		end
	endtask

	// A run closes: if it holds more than one record it is a pile-up, and it
	// is counted, summed and compared with the largest one so far. Only a
	// strictly larger pile-up takes over the largest slot.
	function automatic void close_pile();
		logic [63:0] wide_sum;
		if (run_open && run_len > 1) begin
			if (n_pileups != '1) begin
				n_pileups++;
			end
			wide_sum = 64'(size_total) + 64'(run_len);
			size_total = (wide_sum > 64'(SUM_MAX)) ? SUM_MAX : wide_sum[SUM_W-1:0];
			if (run_len > top_size) begin
				top_size  = run_len;
				top_chrom = cur_chrom;
				top_lo    = run_lo;
				top_hi    = run_hi;
			end
		end
	endfunction

	// Advances the shadow state by one request and returns the summary that
	// the block must report for it.
	function automatic pile_summary_t predict_pileup_stats(item_t it);
		pile_summary_t s;
		logic          same_chrom;
		logic          run_match;
		int            slot;
		if (err_state == ST_OK) begin
			if (it.mode == MODE_END) begin
				// The end marker closes the open run; a second one finds
				// nothing open and adds nothing.
				close_pile();
				run_open = 1'b0;
				run_len  = '0;
			end else begin
				same_chrom = chrom_open && it.chrom == cur_chrom;
				run_match  = run_open && it.start == run_lo && it.stop == run_hi &&
					(!cmp_name || it.name == run_nm);
				if (!same_chrom || !run_match) begin
					close_pile();
				end
				if (!same_chrom) begin
					// A new chromosome must never have been seen before.
					slot = int'(it.chrom) % MAX_CHROMS;
					if (seen_map[slot]) begin
						err_state = ST_REVISIT;
					end else begin
						seen_map[slot] = 1'b1;
						cur_chrom  = it.chrom;
						chrom_open = 1'b1;
						run_open   = 1'b0;
						run_len    = '0;
						run_match  = 1'b0;
					end
				end
				if (err_state == ST_OK && run_open && it.start < run_lo) begin
					err_state = ST_START_DEC;
				end
				if (err_state == ST_OK) begin
					if (run_match) begin
						if (run_len != '1) begin
							run_len++;
						end
					end else begin
						run_open = 1'b1;
						run_lo   = it.start;
						run_hi   = it.stop;
						run_nm   = it.name;
						run_len  = 1;
					end
				end
			end
		end
		s.stats.status     = err_state;
		s.stats.pileups    = n_pileups;
		s.stats.size_sum   = size_total;
		s.stats.best_size  = top_size;
		s.stats.best_chrom = top_chrom;
		s.stats.best_start = top_lo;
		s.stats.best_end   = top_hi;
		s.finished         = it.mode;
		return s;
	endfunction

	task automatic push_record(input logic [CHROM_W-1:0] c, input logic [POS_W-1:0] s,
			input logic [POS_W-1:0] e, input logic [NAME_W-1:0] n);
		item_t it;
		it.mode  = MODE_RECORD;
		it.chrom = c;
		it.start = s;
		it.stop  = e;
		it.name  = n;
		pending_items.push_back(it);
		chrom_taken[c] = 1'b1;
		queued++;
	endtask

	// End markers carry random junk in the fields that they do not use.
	task automatic push_end_marker();
		item_t it;
		it.mode  = MODE_END;
		it.chrom = CHROM_W'($urandom);
		it.start = POS_W'($urandom);
		it.stop  = POS_W'($urandom);
		it.name  = $urandom;
		pending_items.push_back(it);
		queued++;
	endtask

	function automatic logic [CHROM_W-1:0] fresh_chrom();
		logic [CHROM_W-1:0] c;
		do begin
			c = CHROM_W'($urandom_range(0, MAX_CHROMS - 1));
		end while (chrom_taken[c]);
		return c;
	endfunction

	// A well-formed stream on one new chromosome: starts never decrease,
	// and groups of identical records form pile-ups. Some copies carry a
	// different name, which breaks the run only when names are compared.
	// Now and then an end marker falls in the middle of the stream.
	task automatic queue_chrom_stream(input int n_rec);
		logic [CHROM_W-1:0] c;
		longint             pos;
		logic [POS_W-1:0]   stop_pos;
		logic [NAME_W-1:0]  nm;
		int                 dup;
		int                 made;
		c = fresh_chrom();
		case ($urandom_range(0, 2))
			0: pos = 0;
			1: pos = $urandom_range(0, 1000);
			default: pos = $urandom_range(0, 32'h7FFF_0000);
		endcase
		made = 0;
		while (made < n_rec) begin
			case ($urandom_range(0, 9))
				0, 1: pos = pos;
				2: pos = pos + $urandom_range(1, 32'h0FFF_FFFF);
				default: pos = pos + $urandom_range(1, 50);
			endcase
			if (pos > POS_MAX) begin
				pos = POS_MAX;
			end
			case ($urandom_range(0, 5))
				0: stop_pos = POS_W'($urandom);
				1: stop_pos = POS_W'(POS_MAX);
				default: stop_pos = POS_W'(pos + $urandom_range(0, 500));
			endcase
			nm  = $urandom;
			dup = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 5);
			for (int k = 0; k < dup; k++) begin
				push_record(c, POS_W'(pos), stop_pos,
					($urandom_range(0, 4) == 0) ? $urandom : nm);
				made++;
			end
			if ($urandom_range(0, 19) == 0) begin
				push_end_marker();
				made++;
			end
		end
	endtask

	// Configuration is only written with nothing in flight.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_items.size() != 0 || expected_summaries.size() != 0);
	endtask

	task automatic write_compare_name(input logic v);
		@(posedge clk);
		cfg_bus.valid        <= 1'b1;
		cfg_bus.compare_name <= v;
		do begin
			@(posedge clk);
		end while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		cmp_name = v;
	endtask

	// Sender: offers the oldest pending request, holds it until accepted,
	// and works in bursts of random length separated by random gaps. Some
	// bursts are long, which gives stretches with no idling at all.
	always @(posedge clk) begin : item_driver
		logic accepted;
		logic nxt_valid;
		accepted  = item_bus.valid && item_bus.ready;
		nxt_valid = 1'b0;
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
		end else begin
			if (accepted) begin
				expected_summaries.push_back(predict_pileup_stats(pending_items[0]));
				void'(pending_items.pop_front());
			end
			if (item_bus.valid && !accepted) begin
				nxt_valid = 1'b1;
			end else if (gap_left != 0) begin
				gap_left--;
			end else if (pending_items.size() != 0) begin
				nxt_valid = 1'b1;
				item_bus.mode      <= pending_items[0].mode;
				item_bus.chrom_id  <= pending_items[0].chrom;
				item_bus.start_pos <= pending_items[0].start;
				item_bus.end_pos   <= pending_items[0].stop;
				item_bus.name_id   <= pending_items[0].name;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end
			end
			item_bus.valid <= nxt_valid;
		end
	end

	// Receiver: it switches between randomly picked stall styles: always ready,
	// coin flip, mostly stalled, or a fixed on/off pattern.
	always @(posedge clk) begin : result_stall
		logic rdy;
		if (stall_tick % 128 == 0) begin
			stall_style = $urandom_range(0, 3);
		end
		case (stall_style)
			0: rdy = 1'b1;
			1: rdy = $urandom_range(0, 1);
			2: rdy = ($urandom_range(0, 3) == 0);
			default: rdy = ((stall_tick / 4) % 2 == 0);
		endcase
		stall_tick++;
		result_bus.ready <= rdy;
	end

	// Every accepted result is checked field by field against the oldest
	// expected summary.
	always @(posedge clk) begin : result_check
		pile_summary_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_summaries.size() == 0) begin
				flag_failure("result arrived with no request outstanding");
			end else begin
				want = expected_summaries.pop_front();
				check_field("status", result_bus.status, want.stats.status);
				check_field("pileups_found", result_bus.pileups_found, want.stats.pileups);
				check_field("size_sum", result_bus.size_sum, want.stats.size_sum);
				check_field("largest_size", result_bus.largest_size, want.stats.best_size);
				check_field("largest_chrom", result_bus.largest_chrom, want.stats.best_chrom);
				check_field("largest_start", result_bus.largest_start, want.stats.best_start);
				check_field("largest_end", result_bus.largest_end, want.stats.best_end);
				check_field("finished", result_bus.finished, want.finished);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [CHROM_W-1:0] c;
		logic [NAME_W-1:0]  nm;
		arst_n               = 1'b0;
		item_bus.valid       = 1'b0;
		item_bus.mode        = MODE_RECORD;
		item_bus.chrom_id    = '0;
		item_bus.start_pos   = '0;
		item_bus.end_pos     = '0;
		item_bus.name_id     = '0;
		result_bus.ready     = 1'b0;
		cfg_bus.valid        = 1'b0;
		cfg_bus.compare_name = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with names ignored. The write goes in while the
		// seen map is still being cleared; requests simply wait for it.
		write_compare_name(1'b0);
		@(negedge clk);
		push_end_marker();                               // end marker with nothing open
		repeat (3) push_record(10'd0, '0, '0, '0);          // pile-up at all-zero fields
		push_record(10'd0, '0, '0, '1);                      // other name still matches
		push_record(10'd0, '0, POS_W'(POS_MAX), '0);         // new end closes the run
		repeat (2) push_record(10'd0, POS_W'(POS_MAX), POS_W'(POS_MAX), '1);
		push_end_marker();
		push_end_marker();                                   // second marker adds nothing
		repeat (2) push_record(10'd0, 31'd5, 31'd9, 32'd3);  // lower start after a marker
		repeat (3) push_record(10'd1023, 31'd7, 31'd7, 32'd7); // chromosome change closes
		repeat (2) push_record(10'h2AA, 31'h2AAA_AAAA, 31'h5555_5555, 32'hAAAA_AAAA);
		push_end_marker();
		wait_drained();

		// With names compared, a change of name breaks the run.
		write_compare_name(1'b1);
		@(negedge clk);
		nm = $urandom;
		repeat (2) push_record(10'h155, 31'd100, 31'd200, nm);
		repeat (3) push_record(10'h155, 31'd100, 31'd200, ~nm);
		push_end_marker();

		// Random well-formed streams, names compared.
		queued = 0;
		while (queued < 300) begin
			queue_chrom_stream($urandom_range(4, 16));
		end
		wait_drained();

		// Random well-formed streams, names ignored.
		write_compare_name(1'b0);
		@(negedge clk);
		queued = 0;
		while (queued < 300) begin
			queue_chrom_stream($urandom_range(4, 16));
		end
		wait_drained();

		// The error is sticky for the rest of the run, so it comes last: a
		// pile-up, then either a decreasing start or a revisited chromosome,
		// then requests that must leave the statistics frozen.
		write_compare_name(1'b1);
		@(negedge clk);
		c  = fresh_chrom();
		nm = $urandom;
		repeat (2) push_record(c, 31'd1000, 31'd2000, nm);
		if ($urandom_range(0, 1) == 0) begin
			push_record(c, POS_W'($urandom_range(0, 999)), 31'd2000, nm);
		end else begin
			push_record(10'd0, 31'd5000, 31'd6000, nm);
		end
		for (int k = 0; k < 10; k++) begin
			if ($urandom_range(0, 2) == 0) begin
				push_end_marker();
			end else begin
				push_record(CHROM_W'($urandom), POS_W'($urandom), POS_W'($urandom), $urandom);
			end
		end
		wait_drained();

		// The bench waits so that any stray result shows up before the verdict.
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
